### rtl/bmba_pkg.sv
// Shared constants and types for the bitmap block allocator.
package bmba_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int BYTES_W    = 24;
  localparam int OBJ_W      = 16;
  localparam int BSIZE_W    = 16;
  localparam int PROD_W     = BYTES_W + OBJ_W;
  localparam int DIVD_W     = PROD_W + 1;
  localparam int QCNT_W     = $clog2(DIVD_W + 1);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [15:0] BSIZE_RESET = 16'd64;

  typedef struct packed {
    logic                  start;
    logic [DIVD_W-1:0]     dividend;
    logic [BSIZE_W-1:0]    divisor;
  } div_req_t;

endpackage

### rtl/bmba_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bmba_div
  import bmba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0]  quo;
  logic [BSIZE_W-1:0] rem;
  logic [BSIZE_W-1:0] dvs;
  logic [QCNT_W-1:0]  cnt;
  logic               busy;
  logic [BSIZE_W:0]   trial;
  logic               ge;

  assign trial    = {rem, quo[DIVD_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= QCNT_W'(DIVD_W);
        quo  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? BSIZE_W'(trial - {1'b0, dvs}) : trial[BSIZE_W-1:0];
        quo <= {quo[DIVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == QCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/bitmap_block_allocator_core.sv
// Top level of the bitmap first-fit block allocator.
//
// Requests arrive on the s_axis channel, one beat per request; s_axis_tuser
// carries the opcode (allocate or free). Each request gives one result beat
// on m_axis. The block handles one request at a time: s_axis_tready is high
// only while the sequencer is idle.
// After acceptance a request passes through the product, the checks and the
// ceiling division (one quotient bit per cycle). An allocate then walks the
// map for the first fit over up to 256 blocks, one block per cycle; a request
// that changes the map then marks it and walks all 256 blocks for the longest
// run. Last the result is loaded; a request with zero size or zero block size
// goes from the checks straight to the result.
// A finished result sits in the output register until taken; while it waits
// the next request may be accepted and processed, and the sequencer holds
// its next result until the output register is free.
// Reset marks every block free, sets the free count and longest run to the
// block count and the block size register to 64. cfg_we writes the block
// size; the user must use it only while the block is idle, as the block does not enforce this.
module bitmap_block_allocator_core
  import bmba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [BSIZE_W-1:0] cfg_wdata,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,  // byte_count, object_count, start_block
  input  logic               s_axis_tuser,  // opcode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata   // status, block_index, free_count, largest_run
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FIT  = 3'd4;
  localparam logic [2:0] S_MARK = 3'd5;
  localparam logic [2:0] S_LONG = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]            state;
  logic [BSIZE_W-1:0]    blk_bytes;
  logic [NUM_BLOCKS-1:0] free_map;
  logic [CNT_W-1:0]      free_blocks;
  logic [CNT_W-1:0]      longest_run;
  logic                  opcode;
  logic [BYTES_W-1:0]    bytes;
  logic [OBJ_W-1:0]      objs;
  logic [IDX_W-1:0]      start;
  logic [PROD_W-1:0]     total;
  logic [CNT_W-1:0]      nblk;
  logic [IDX_W-1:0]      pos;
  logic [CNT_W-1:0]      run;
  logic [CNT_W-1:0]      best;
  logic [1:0]            status;
  logic [IDX_W-1:0]      index_out;
  div_req_t              div_req;
  logic                  div_done;
  logic [DIVD_W-1:0]     quotient;
  logic [CNT_W-1:0]      run_next;
  logic [NUM_BLOCKS-1:0] range_mask;
  logic [CNT_W:0]        sum;
  logic [CNT_W:0]        room;
  logic                  out_load;

  assign s_axis_tready = (state == S_IDLE);

  assign div_req.start    = (state == S_CHK) && (blk_bytes != '0) && (total != '0);
  assign div_req.dividend = DIVD_W'(total) + DIVD_W'(blk_bytes) - DIVD_W'(1);
  assign div_req.divisor  = blk_bytes;

  bmba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  assign run_next   = free_map[pos] ? CNT_W'(run + 1'b1) : '0;
  assign range_mask = (~({NUM_BLOCKS{1'b1}} << nblk)) << start;
  assign sum        = (CNT_W + 1)'(free_blocks) + (CNT_W + 1)'(nblk);
  assign room       = (CNT_W + 1)'(NUM_BLOCKS) - (CNT_W + 1)'(start);
  assign out_load   = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      blk_bytes     <= BSIZE_RESET;
      free_map      <= '1;
      free_blocks   <= CNT_W'(NUM_BLOCKS);
      longest_run   <= CNT_W'(NUM_BLOCKS);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        blk_bytes <= cfg_wdata;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {4'd0, longest_run, free_blocks, index_out, status};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            opcode <= s_axis_tuser;
            bytes  <= s_axis_tdata[23:0];
            objs   <= s_axis_tdata[39:24];
            start  <= s_axis_tdata[47:40];
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          total     <= (opcode == OP_FREE) ? PROD_W'(bytes) * PROD_W'(objs) : PROD_W'(bytes);
          status    <= ST_BAD;
          index_out <= '0;
          state     <= S_CHK;
        end
        S_CHK: begin
          if (blk_bytes == '0 || total == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            nblk <= quotient[CNT_W-1:0];
            pos  <= '0;
            run  <= '0;
            if (opcode == OP_ALLOC) begin
              if (quotient > DIVD_W'(NUM_BLOCKS)) begin
                state <= S_DONE;
              end else begin
                status <= ST_NO_FIT;
                state  <= S_FIT;
              end
            end else if (quotient > DIVD_W'(room)) begin
              state <= S_DONE;
            end else begin
              state <= S_MARK;
            end
          end
        end
        S_FIT: begin
          run <= run_next;
          pos <= pos + 1'b1;
          if (run_next >= nblk) begin
            start <= IDX_W'(CNT_W'(pos) + CNT_W'(1) - nblk);
            state <= S_MARK;
          end else if (pos == IDX_W'(NUM_BLOCKS - 1)) begin
            state <= S_DONE;
          end
        end
        S_MARK: begin
          status <= ST_OK;
          if (opcode == OP_ALLOC) begin
            free_map    <= free_map & ~range_mask;
            free_blocks <= (free_blocks >= nblk) ? CNT_W'(free_blocks - nblk) : '0;
            index_out   <= start;
          end else begin
            free_map    <= free_map | range_mask;
            free_blocks <= (sum >= (CNT_W + 1)'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                              : sum[CNT_W-1:0];
          end
          pos   <= '0;
          run   <= '0;
          best  <= '0;
          state <= S_LONG;
        end
        S_LONG: begin
          run <= run_next;
          pos <= pos + 1'b1;
          if (pos == IDX_W'(NUM_BLOCKS - 1)) begin
            longest_run <= (run_next > best) ? run_next : best;
            state       <= S_DONE;
          end else if (run_next > best) begin
            best <= run_next;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
